/* rtl/utf8sd_pkg.sv */
// ---------------------------------------------------------------------------
// utf8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Transfer payloads, the result-run descriptor and Unicode range limits.
// ---------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned CntW = 3;

  localparam logic [CpW-1:0] ReplacementCp = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxScalar     = 21'h10FFFF;
  localparam logic [CpW-1:0] Min4Byte      = 21'h010000;
  localparam logic [CpW-1:0] Min3Byte      = 21'h000800;
  localparam logic [CpW-1:0] Min2Byte      = 21'h000080;
  localparam logic [CpW-1:0] SurrogateLo   = 21'h00D800;
  localparam logic [CpW-1:0] SurrogateHi   = 21'h00DFFF;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] PayMask  = 8'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic            invalid;
    logic [CntW-1:0] byte_count;
    logic            run_last;
    logic            stream_done;
  } out_item_t;

  // Open-sequence bookkeeping (count/length are reset, bytes are not)
  typedef struct packed {
    logic [1:0] pend_cnt;
    logic [2:0] exp_len;
  } seq_ctl_t;

  // Results of one input byte: errors, at most one decoded value, errors
  typedef struct packed {
    logic [2:0]      count;     // 0..4 results
    logic            has_val;
    logic [1:0]      val_pos;   // slot of the decoded value
    logic [CpW-1:0]  val_cp;
    logic [CntW-1:0] val_len;
    logic            eos;
  } run_t;

endpackage

/* rtl/utf8sd_decode.sv */
// ---------------------------------------------------------------------------
// utf8sd_decode: per-byte decode step
// Classifies one byte against the open sequence, builds the result run and
// the next sequence state.
// ---------------------------------------------------------------------------
module utf8sd_decode (
  input  utf8sd_pkg::in_item_t  item_i,
  input  utf8sd_pkg::seq_ctl_t  ctl_i,
  input  logic [2:0][7:0]       bytes_i,
  output utf8sd_pkg::seq_ctl_t  ctl_o,
  output logic [2:0][7:0]       bytes_o,
  output utf8sd_pkg::run_t      run_o
);
  import utf8sd_pkg::*;

  logic [7:0]     c;
  logic           is_ascii, is_cont, lead2, lead3, lead4;
  logic           scan;
  logic [2:0]     pre, post;
  logic [CpW-1:0] x;
  logic           x_ok;

  assign c        = item_i.data_byte;
  assign is_ascii = ~c[7];
  assign is_cont  = (c & ContMask) == ContTag;
  assign lead2    = c[7:5] == 3'b110;
  assign lead3    = c[7:4] == 4'b1110;
  assign lead4    = c[7:3] == 5'b11110;

  // Scalar of the sequence closed by c, and its legality
  always_comb begin
    x    = '0;
    x_ok = 1'b0;
    unique case (ctl_i.exp_len)
      3'd2: begin
        x    = CpW'({bytes_i[0][4:0], c[5:0]});
        x_ok = x >= Min2Byte;
      end
      3'd3: begin
        x    = CpW'({bytes_i[0][3:0], bytes_i[1][5:0], c[5:0]});
        x_ok = (x >= Min3Byte) && !((x >= SurrogateLo) && (x <= SurrogateHi));
      end
      default: begin
        x    = {bytes_i[0][2:0], bytes_i[1][5:0], bytes_i[2][5:0], c[5:0]};
        x_ok = (x >= Min4Byte) && (x <= MaxScalar);
      end
    endcase
  end

  always_comb begin
    ctl_o         = ctl_i;
    bytes_o       = bytes_i;
    pre           = '0;
    post          = '0;
    scan          = 1'b0;
    run_o.has_val = 1'b0;
    run_o.val_cp  = CpW'(c);
    run_o.val_len = CntW'(1);

    if (ctl_i.pend_cnt == 2'd0 || ctl_i.exp_len == 3'd0) begin
      scan = 1'b1;
    end else if (is_cont) begin
      if ({1'b0, ctl_i.pend_cnt} + 3'd1 < ctl_i.exp_len) begin
        bytes_o[ctl_i.pend_cnt] = c;
        ctl_o.pend_cnt          = ctl_i.pend_cnt + 2'd1;
      end else begin
        if (x_ok) begin
          run_o.has_val = 1'b1;
          run_o.val_cp  = x;
          run_o.val_len = ctl_i.exp_len;
        end else begin
          pre = ctl_i.exp_len;
        end
        ctl_o = '0;
      end
    end else begin
      // lead and held continuations are all flagged, then c starts over
      pre  = {1'b0, ctl_i.pend_cnt};
      scan = 1'b1;
    end

    if (scan) begin
      ctl_o = '0;
      if (is_ascii) begin
        run_o.has_val = 1'b1;
      end else if (lead2 || lead3 || lead4) begin
        ctl_o.pend_cnt = 2'd1;
        ctl_o.exp_len  = lead2 ? 3'd2 : (lead3 ? 3'd3 : 3'd4);
        bytes_o[0]     = c;
      end else begin
        pre = pre + 3'd1;
      end
    end

    // truncated sequence at end of stream
    if (item_i.end_of_stream) begin
      post  = {1'b0, ctl_o.pend_cnt};
      ctl_o = '0;
    end

    run_o.count   = pre + {2'b00, run_o.has_val} + post;
    run_o.val_pos = pre[1:0];
    run_o.eos     = item_i.end_of_stream;
  end

endmodule

/* rtl/utf8sd_emit.sv */
// ---------------------------------------------------------------------------
// utf8sd_emit: result run register and output sequencer
// Holds the run of one byte and hands out its results one transfer a cycle while out_ready_i is high.
// ---------------------------------------------------------------------------
module utf8sd_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  utf8sd_pkg::run_t       run_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output utf8sd_pkg::out_item_t  out_item_o
);
  import utf8sd_pkg::*;

  run_t       run_q;
  logic       valid_q;
  logic [2:0] idx_q;
  logic       last;
  logic       is_val;

  assign last        = idx_q == (run_q.count - 3'd1);
  assign is_val      = run_q.has_val && (idx_q == {1'b0, run_q.val_pos});
  assign out_valid_o = valid_q;
  assign free_o      = !valid_q || (out_ready_i && last);

  always_comb begin
    out_item_o.code_point  = is_val ? run_q.val_cp : ReplacementCp;
    out_item_o.invalid     = !is_val;
    out_item_o.byte_count  = is_val ? run_q.val_len : CntW'(1);
    out_item_o.run_last    = last;
    out_item_o.stream_done = last && run_q.eos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free_o) begin
      valid_q <= load_i;
      idx_q   <= '0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      run_q <= run_i;
    end
  end

endmodule

/* rtl/utf8_strict_stream_decoder_top.sv */
// ---------------------------------------------------------------------------
// utf8_strict_stream_decoder_top: strict streaming UTF-8 decoder
// Byte stream in, Unicode scalar values out, one result per transfer.
// ---------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_item_i): one raw byte per transfer,
//    end_of_stream set on the final byte flushes a truncated sequence.
//  - out channel (out_valid_o/out_ready_i/out_item_o): one result per
//    transfer; run_last marks the last result caused by a byte,
//    stream_done the final result of the stream.
//  - A byte passes the input register, then the run register, which offers
//    its first result.
//  - Throughput: one byte per cycle while out_ready_i is high and each byte
//    yields at most one result. A byte with more results (up to four, error
//    runs) holds the run register until all are taken; this stalls the input.
//  - Bytes that only extend an open sequence yield no result and pass at
//    full rate while the run register is free.
//  - When the receiver stalls, the run register holds its result and an
//    empty input register still takes one more byte before in_ready_o drops.
//  - Reset empties both registers and closes any open sequence; the held
//    sequence bytes themselves are not cleared.
// ---------------------------------------------------------------------------
module utf8_strict_stream_decoder_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  utf8sd_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output utf8sd_pkg::out_item_t  out_item_o
);
  import utf8sd_pkg::*;

  // input register
  in_item_t        inq_q;
  logic            inq_valid_q;

  // open-sequence state
  seq_ctl_t        ctl_q, ctl_d;
  logic [2:0][7:0] bytes_q, bytes_d;

  run_t            run;
  logic            emit_free;
  logic            consume;

  // the held byte moves on whenever the run register can take its results
  assign consume    = inq_valid_q && emit_free;
  assign in_ready_o = !inq_valid_q || emit_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      ctl_q       <= '0;
    end else begin
      if (in_ready_o) begin
        inq_valid_q <= in_valid_i;
      end
      if (consume) begin
        ctl_q <= ctl_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      inq_q <= in_item_i;
    end
    if (consume) begin
      bytes_q <= bytes_d;
    end
  end

  utf8sd_decode u_decode (
    .item_i  (inq_q),
    .ctl_i   (ctl_q),
    .bytes_i (bytes_q),
    .ctl_o   (ctl_d),
    .bytes_o (bytes_d),
    .run_o   (run)
  );

  // bytes that only extend a sequence load nothing
  utf8sd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && (run.count != 3'd0)),
    .run_i       (run),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
